>>> hw/rtl/perceptron_train_evaluate_assert.svh
// ----------------------------------------------------------------------------
// Perceptron assertion macros
// Clocked, reset-gated assertion shorthands used by the perceptron_train_evaluate module.
// ----------------------------------------------------------------------------
`ifndef PERCEPTRON_TRAIN_EVALUATE_ASSERT_SVH
`define PERCEPTRON_TRAIN_EVALUATE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define PTE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PTE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/pte_pkg.sv
// ----------------------------------------------------------------------------
// pte_pkg
// Shared widths, codes and types of the two-input perceptron block.
// ----------------------------------------------------------------------------
package pte_pkg;

    localparam int MAX_SAMPLES = 256;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

    localparam int FEAT_W   = 16;
    localparam int WEIGHT_W = 32;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    localparam int PCT_SCALE  = 100;
    localparam int ACC_W      = 7;
    localparam int DIVIDEND_W = CNT_W + ACC_W;
    localparam int DIVISOR_W  = CNT_W;

    localparam logic [CFG_W-1:0] LR_RESET    = 16'd6554;
    localparam logic [CFG_W-1:0] EPOCH_RESET = 16'd1;

    localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EPOCH_COUNT   = 2'd1;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_RUN  = 1'b1;

    typedef struct packed {
        logic signed [FEAT_W-1:0] fa;
        logic signed [FEAT_W-1:0] fb;
        logic                     lab;
    } sample_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_MUL,
        ST_ACT,
        ST_UPD,
        ST_DIV,
        ST_WAIT
    } state_t;

endpackage

>>> hw/rtl/pte_sample_ram.sv
// ----------------------------------------------------------------------------
// pte_sample_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pte_sample_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 33
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/pte_div.sv
// ----------------------------------------------------------------------------
// pte_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pte_div import pte_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic                  done
);

    localparam int CW = $clog2(DIVIDEND_W + 1);

    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  run_reg, run_next;
    logic                  done_reg, done_next;

    logic [DIVISOR_W:0] shifted;
    logic [DIVISOR_W:0] diff;
    logic               fits;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DIVIDEND_W-1]};
        fits      = shifted >= {1'b0, divisor};
        diff      = shifted - {1'b0, divisor};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            cnt_next = CW'(DIVIDEND_W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            // remainder stays below the divisor, so the low bits hold it
            rem_next = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

>>> hw/rtl/perceptron_train_evaluate.sv
// ----------------------------------------------------------------------------
// perceptron_train_evaluate
// Two-input perceptron with a sample memory, online training and scoring.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken when start is high and busy is low. mode 0 loads one
//   sample (feature_a, feature_b, label) into the sample memory; loads run back
//   to back with busy low, and loads past capacity are dropped.
//   mode 1 clears the weights, trains over all stored samples for epoch_count
//   passes, then rescores every sample with the final weights.
//   Each sample visit runs the memory read, multiply, activation and update
//   steps in order; the next visit waits for the update, set by the weight
//   dependency from one sample to the next. A run ends with the serial
//   accuracy divider (one quotient bit per cycle). A run with no samples
//   answers in the cycle after it is taken, empty_flag set. The result is
//   shown for one cycle with done high; the receiver cannot stall it, and
//   busy is already low in that cycle. Configuration writes (cfg_valid,
//   cfg_ready always high) must go in while idle; the block does not enforce
//   it. Reset clears the sample count and weights and loads the default
//   learning rate and epoch count; the sample memory needs no clearing.
// ----------------------------------------------------------------------------
`include "perceptron_train_evaluate_assert.svh"

module perceptron_train_evaluate import pte_pkg::*; (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       mode,
    input  logic signed [FEAT_W-1:0]   feature_a,
    input  logic signed [FEAT_W-1:0]   feature_b,
    input  logic                       label,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]           cfg_data,
    output logic                       done,
    output logic [ACC_W-1:0]           accuracy_percent,
    output logic [CNT_W-1:0]           correct_count,
    output logic [CNT_W-1:0]           sample_total,
    output logic signed [WEIGHT_W-1:0] bias_weight,
    output logic signed [WEIGHT_W-1:0] weight_first,
    output logic signed [WEIGHT_W-1:0] weight_second,
    output logic                       empty_flag
);

    localparam int PROD_W = WEIGHT_W + FEAT_W;
    localparam int ACT_W  = PROD_W + 2;
    localparam int DRAW_W = CFG_W + 1 + FEAT_W;
    localparam int DELTA_W = DRAW_W - 8;
    localparam int SUM_W  = WEIGHT_W + 2;

    function automatic logic signed [WEIGHT_W-1:0] sat_w(input logic signed [SUM_W-1:0] s);
        logic signed [WEIGHT_W-1:0] r;
        if (s[SUM_W-1:WEIGHT_W-1] == '0 || s[SUM_W-1:WEIGHT_W-1] == '1)
        begin
            r = s[WEIGHT_W-1:0];
        end
        else if (s[SUM_W-1])
        begin
            r = {1'b1, {(WEIGHT_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(WEIGHT_W-1){1'b1}}};
        end
        return r;
    endfunction

    // configuration
    logic [CFG_W-1:0] lr_reg;
    logic [CFG_W-1:0] epochs_reg;

    // control
    state_t                     state_reg, state_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [ADDR_W-1:0]          j_reg, j_next;
    logic [CFG_W-1:0]           e_reg, e_next;
    logic                       train_reg, train_next;
    logic [CNT_W-1:0]           correct_reg, correct_next;
    logic                       done_reg, done_next;
    logic                       empty_reg, empty_next;
    logic [ACC_W-1:0]           acc_reg, acc_next;
    logic signed [WEIGHT_W-1:0] bias_reg, bias_next;
    logic signed [WEIGHT_W-1:0] w1_reg, w1_next;
    logic signed [WEIGHT_W-1:0] w2_reg, w2_next;

    // datapath
    logic signed [PROD_W-1:0]   p1_reg, p1_next;
    logic signed [PROD_W-1:0]   p2_reg, p2_next;
    logic signed [DELTA_W-1:0]  d1_reg, d1_next;
    logic signed [DELTA_W-1:0]  d2_reg, d2_next;
    logic                       pred_reg, pred_next;

    logic                       accept, run_accept;
    logic                       ram_we, ram_re;
    logic [ADDR_W-1:0]          ram_raddr;
    logic [$bits(sample_t)-1:0] ram_rdata;
    sample_t                    wr_smp, smp;

    logic signed [DRAW_W-1:0]   draw1, draw2;
    logic signed [ACT_W-1:0]    act;
    logic signed [SUM_W-1:0]    step_b, step1, step2;
    logic                       last_sample;

    logic                       div_start, div_done;
    logic [DIVIDEND_W-1:0]      div_q;
    logic [DIVIDEND_W-1:0]      div_num;

    assign busy       = (state_reg != ST_IDLE);
    assign accept     = start && !busy;
    assign run_accept = accept && (mode == MODE_RUN);
    assign cfg_ready  = 1'b1;

    assign ram_we = accept && (mode == MODE_LOAD) && (count_reg < CNT_W'(MAX_SAMPLES));
    assign wr_smp = '{fa: feature_a, fb: feature_b, lab: label};
    assign smp    = ram_rdata;

    pte_sample_ram #(
        .DEPTH (MAX_SAMPLES),
        .WIDTH ($bits(sample_t))
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (wr_smp),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign div_num = DIVIDEND_W'(correct_reg) * DIVIDEND_W'(PCT_SCALE);

    pte_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (count_reg),
        .quotient (div_q),
        .done     (div_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg     <= LR_RESET;
            epochs_reg <= EPOCH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_LEARNING_RATE: lr_reg     <= cfg_data;
                REG_EPOCH_COUNT:   epochs_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        j_next       = j_reg;
        e_next       = e_reg;
        train_next   = train_reg;
        correct_next = correct_reg;
        done_next    = 1'b0;
        empty_next   = empty_reg;
        acc_next     = acc_reg;
        bias_next    = bias_reg;
        w1_next      = w1_reg;
        w2_next      = w2_reg;
        ram_re       = 1'b0;
        ram_raddr    = j_reg;
        div_start    = 1'b0;

        draw1     = $signed({1'b0, lr_reg}) * smp.fa;
        draw2     = $signed({1'b0, lr_reg}) * smp.fb;
        p1_next   = w1_reg * smp.fa;
        p2_next   = w2_reg * smp.fb;
        // arithmetic shift right by 8 floors toward minus infinity
        d1_next   = draw1[DRAW_W-1:8];
        d2_next   = draw2[DRAW_W-1:8];

        act = {{(ACT_W-WEIGHT_W-8){bias_reg[WEIGHT_W-1]}}, bias_reg, 8'd0}
            + {{2{p1_reg[PROD_W-1]}}, p1_reg}
            + {{2{p2_reg[PROD_W-1]}}, p2_reg};
        pred_next = ~act[ACT_W-1];

        // a mismatch with label 1 means the prediction was 0: step up
        step_b = smp.lab ? $signed({{(SUM_W-CFG_W){1'b0}}, lr_reg})
                         : -$signed({{(SUM_W-CFG_W){1'b0}}, lr_reg});
        step1  = smp.lab ? SUM_W'(d1_reg) : -SUM_W'(d1_reg);
        step2  = smp.lab ? SUM_W'(d2_reg) : -SUM_W'(d2_reg);

        last_sample = (CNT_W'(j_reg) == count_reg - 1'b1);

        case (state_reg)
            ST_IDLE:
            begin
                if (ram_we)
                begin
                    count_next = count_reg + 1'b1;
                end
                if (run_accept)
                begin
                    bias_next    = '0;
                    w1_next      = '0;
                    w2_next      = '0;
                    correct_next = '0;
                    j_next       = '0;
                    e_next       = '0;
                    train_next   = (epochs_reg != '0);
                    if (count_reg == '0)
                    begin
                        done_next  = 1'b1;
                        empty_next = 1'b1;
                        acc_next   = '0;
                    end
                    else
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                ram_re     = 1'b1;
                ram_raddr  = j_reg;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_ACT;
            end
            ST_ACT:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (train_reg)
                begin
                    if (pred_reg != smp.lab)
                    begin
                        bias_next = sat_w({{2{bias_reg[WEIGHT_W-1]}}, bias_reg} + step_b);
                        w1_next   = sat_w({{2{w1_reg[WEIGHT_W-1]}}, w1_reg} + step1);
                        w2_next   = sat_w({{2{w2_reg[WEIGHT_W-1]}}, w2_reg} + step2);
                    end
                end
                else if (pred_reg == smp.lab)
                begin
                    correct_next = correct_reg + 1'b1;
                end

                if (!last_sample)
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_MUL;
                end
                else
                begin
                    j_next = '0;
                    if (train_reg)
                    begin
                        state_next = ST_MUL;
                        if (e_reg == epochs_reg - 1'b1)
                        begin
                            train_next = 1'b0;
                        end
                        else
                        begin
                            e_next = e_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
                // prefetch the next sample for the following visit
                ram_re    = (state_next == ST_MUL);
                ram_raddr = j_next;
            end
            ST_DIV:
            begin
                div_start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (div_done)
                begin
                    acc_next   = div_q[ACC_W-1:0];
                    empty_next = 1'b0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            j_reg       <= '0;
            e_reg       <= '0;
            train_reg   <= 1'b0;
            correct_reg <= '0;
            done_reg    <= 1'b0;
            empty_reg   <= 1'b0;
            acc_reg     <= '0;
            bias_reg    <= '0;
            w1_reg      <= '0;
            w2_reg      <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            j_reg       <= j_next;
            e_reg       <= e_next;
            train_reg   <= train_next;
            correct_reg <= correct_next;
            done_reg    <= done_next;
            empty_reg   <= empty_next;
            acc_reg     <= acc_next;
            bias_reg    <= bias_next;
            w1_reg      <= w1_next;
            w2_reg      <= w2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg   <= p1_next;
        p2_reg   <= p2_next;
        d1_reg   <= d1_next;
        d2_reg   <= d2_next;
        pred_reg <= pred_next;
    end

    assign done             = done_reg;
    assign empty_flag       = empty_reg;
    assign accuracy_percent = acc_reg;
    assign correct_count    = correct_reg;
    assign sample_total     = count_reg;
    assign bias_weight      = bias_reg;
    assign weight_first     = w1_reg;
    assign weight_second    = w2_reg;

    `PTE_ASSERT_NOW(a_correct_le_total, 1'b1, correct_reg <= count_reg, "correct count above total")
    `PTE_ASSERT_NOW(a_index_in_range, busy, CNT_W'(j_reg) < count_reg, "sample index past count")
    `PTE_ASSERT_NEXT(a_run_goes_busy, run_accept && count_reg != '0, busy, "run did not start")
    `PTE_ASSERT_NOW(a_div_done_in_wait, div_done, state_reg == ST_WAIT, "divider done out of turn")
    `PTE_ASSERT_NOW(a_acc_bounded, done_reg, acc_reg <= ACC_W'(PCT_SCALE), "accuracy above 100")

endmodule
